// ===== hdl/nsq_pkg.sv =====
package nsq_pkg;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef logic signed [23:0] pos_t;
  typedef logic signed [15:0] dir_t;
  typedef logic [23:0]        len_t;
  typedef logic [51:0]        dsq_t;

  localparam dsq_t DIST_MAX = '1;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] idx;
    pos_t       px;
    pos_t       py;
    pos_t       pz;
    dir_t       dx;
    dir_t       dy;
    dir_t       dz;
    len_t       len;
    logic       act;
  } cmd_t;

  typedef struct packed {
    pos_t sx;
    pos_t sy;
    pos_t sz;
    dir_t dx;
    dir_t dy;
    dir_t dz;
    len_t len;
  } entry_t;

endpackage

// ===== hdl/nsq_ram.sv =====
module nsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/nsq_front.sv =====
module nsq_front #(
  parameter int SEGMENT_COUNT = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_action,
  input  logic [5:0]     in_seg_index,
  input  nsq_pkg::pos_t  in_point_x,
  input  nsq_pkg::pos_t  in_point_y,
  input  nsq_pkg::pos_t  in_point_z,
  input  nsq_pkg::dir_t  in_dir_x,
  input  nsq_pkg::dir_t  in_dir_y,
  input  nsq_pkg::dir_t  in_dir_z,
  input  nsq_pkg::len_t  in_seg_length,
  input  logic           in_active_flag,
  output logic           q_valid,
  input  logic           q_ready,
  output nsq_pkg::cmd_t  q_cmd
);
  import nsq_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep, push, pop;
  cmd_t       cmd;

  // drop unknown actions and out-of-table writes here
  always_comb begin
    keep = (in_action == ACT_QUERY) ||
           (((in_action == ACT_LOAD) || (in_action == ACT_SET)) &&
            (32'(in_seg_index) < SEGMENT_COUNT));
    cmd.kind = in_action;
    cmd.idx  = in_seg_index;
    cmd.px   = in_point_x;
    cmd.py   = in_point_y;
    cmd.pz   = in_point_z;
    cmd.dx   = in_dir_x;
    cmd.dy   = in_dir_y;
    cmd.dz   = in_dir_z;
    cmd.len  = in_seg_length;
    cmd.act  = in_active_flag;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rp_r];
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd;
    end
  end
endmodule

// ===== hdl/nsq_dist.sv =====
module nsq_dist #(
  parameter int IW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            iss_go,
  input  logic            iss_use,
  input  logic            iss_last,
  input  logic [IW-1:0]   iss_idx,
  input  nsq_pkg::entry_t ent,
  input  nsq_pkg::pos_t   px,
  input  nsq_pkg::pos_t   py,
  input  nsq_pkg::pos_t   pz,
  output logic            res_go,
  output logic            res_use,
  output logic            res_last,
  output logic [IW-1:0]   res_idx,
  output nsq_pkg::len_t   res_s,
  output nsq_pkg::dsq_t   res_dsq
);
  import nsq_pkg::*;

  localparam int NS = 8;

  logic          go_r   [NS];
  logic          use_r  [NS];
  logic          last_r [NS];
  logic [IW-1:0] idx_r  [NS];

  // entry carried to the closest-point stage
  entry_t e1_r, e2_r, e3_r, e4_r;
  len_t   s3_r, s4_r, s5_r, s6_r, s7_r;

  logic signed [24:0] d1x_r, d1y_r, d1z_r;
  logic signed [40:0] m2x_r, m2y_r, m2z_r;
  logic signed [40:0] q4x_r, q4y_r, q4z_r;
  logic signed [28:0] d5x_r, d5y_r, d5z_r;
  logic signed [57:0] sq6x_r, sq6y_r, sq6z_r;
  dsq_t               dsq7_r;

  logic signed [42:0] dot;
  logic signed [28:0] proj;
  len_t               s_nxt;
  logic signed [24:0] s_sgn;
  logic signed [27:0] cx, cy, cz;
  logic [59:0]        ssum;
  dsq_t               dsq_nxt;

  always_comb begin
    dot  = 43'(m2x_r) + 43'(m2y_r) + 43'(m2z_r);
    proj = 29'(dot >>> 14);
    if (proj < 0) begin
      s_nxt = '0;
    end else if (proj > $signed({5'b0, e2_r.len})) begin
      s_nxt = e2_r.len;
    end else begin
      s_nxt = proj[23:0];
    end
    s_sgn = $signed({1'b0, s3_r});
    cx = 28'(e4_r.sx) + 28'(q4x_r >>> 14);
    cy = 28'(e4_r.sy) + 28'(q4y_r >>> 14);
    cz = 28'(e4_r.sz) + 28'(q4z_r >>> 14);
    ssum = 60'($unsigned(sq6x_r)) + 60'($unsigned(sq6y_r)) + 60'($unsigned(sq6z_r));
    dsq_nxt = (ssum > 60'(DIST_MAX)) ? DIST_MAX : ssum[51:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        go_r[k] <= 1'b0;
      end
    end else begin
      go_r[0] <= iss_go;
      for (int k = 1; k < NS; k++) begin
        go_r[k] <= go_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    use_r[0]  <= iss_use;
    last_r[0] <= iss_last;
    idx_r[0]  <= iss_idx;
    // stage 1 sees the RAM data for stage 0's tag
    use_r[1]  <= use_r[0] && (ent.len != '0);
    for (int k = 2; k < NS; k++) begin
      use_r[k] <= use_r[k-1];
    end
    for (int k = 1; k < NS; k++) begin
      last_r[k] <= last_r[k-1];
      idx_r[k]  <= idx_r[k-1];
    end

    e1_r  <= ent;
    d1x_r <= 25'(px) - 25'(ent.sx);
    d1y_r <= 25'(py) - 25'(ent.sy);
    d1z_r <= 25'(pz) - 25'(ent.sz);

    e2_r  <= e1_r;
    m2x_r <= 41'(d1x_r) * 41'(e1_r.dx);
    m2y_r <= 41'(d1y_r) * 41'(e1_r.dy);
    m2z_r <= 41'(d1z_r) * 41'(e1_r.dz);

    e3_r <= e2_r;
    s3_r <= s_nxt;

    e4_r  <= e3_r;
    s4_r  <= s3_r;
    q4x_r <= 41'(e3_r.dx) * 41'(s_sgn);
    q4y_r <= 41'(e3_r.dy) * 41'(s_sgn);
    q4z_r <= 41'(e3_r.dz) * 41'(s_sgn);

    s5_r  <= s4_r;
    d5x_r <= 29'(px) - 29'(cx);
    d5y_r <= 29'(py) - 29'(cy);
    d5z_r <= 29'(pz) - 29'(cz);

    s6_r   <= s5_r;
    sq6x_r <= 58'(d5x_r) * 58'(d5x_r);
    sq6y_r <= 58'(d5y_r) * 58'(d5y_r);
    sq6z_r <= 58'(d5z_r) * 58'(d5z_r);

    s7_r   <= s6_r;
    dsq7_r <= dsq_nxt;
  end

  assign res_go   = go_r[NS-1];
  assign res_use  = use_r[NS-1];
  assign res_last = last_r[NS-1];
  assign res_idx  = idx_r[NS-1];
  assign res_s    = s7_r;
  assign res_dsq  = dsq7_r;
endmodule

// ===== hdl/nsq_back.sv =====
module nsq_back #(
  parameter int SEGMENT_COUNT = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  nsq_pkg::cmd_t  q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_found,
  output logic [5:0]     out_lane_index,
  output nsq_pkg::len_t  out_along_distance,
  output nsq_pkg::dsq_t  out_dist_sq
);
  import nsq_pkg::*;

  localparam int IW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SEGMENT_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]               st_r, st_nxt;
  logic [SEGMENT_COUNT-1:0] active_r, active_nxt, loaded_r, loaded_nxt;
  logic [IW-1:0]            cnt_r, cnt_nxt;
  pos_t                     px_r, py_r, pz_r;
  logic                     found_r, found_nxt;
  logic [IW-1:0]            bidx_r, bidx_nxt;
  len_t                     bs_r, bs_nxt;
  dsq_t                     bd_r, bd_nxt;
  logic                     ov_r, ov_nxt;
  logic                     of_r;
  logic [5:0]               oi_r;
  len_t                     os_r;
  dsq_t                     od_r;
  logic                     load_out;

  logic [IW-1:0] widx;
  logic          we;
  entry_t        wentry, rentry;
  logic          iss_go, iss_use, iss_last;
  logic          res_go, res_use, res_last;
  logic [IW-1:0] res_idx;
  len_t          res_s;
  dsq_t          res_dsq;

  assign widx = IW'(q_cmd.idx);
  assign wentry = '{sx: q_cmd.px, sy: q_cmd.py, sz: q_cmd.pz,
                    dx: q_cmd.dx, dy: q_cmd.dy, dz: q_cmd.dz, len: q_cmd.len};

  nsq_ram #(.WIDTH($bits(entry_t)), .DEPTH(SEGMENT_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (widx),
    .wdata (wentry),
    .raddr (cnt_r),
    .rdata (rentry)
  );

  nsq_dist #(.IW(IW)) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss_go   (iss_go),
    .iss_use  (iss_use),
    .iss_last (iss_last),
    .iss_idx  (cnt_r),
    .ent      (rentry),
    .px       (px_r),
    .py       (py_r),
    .pz       (pz_r),
    .res_go   (res_go),
    .res_use  (res_use),
    .res_last (res_last),
    .res_idx  (res_idx),
    .res_s    (res_s),
    .res_dsq  (res_dsq)
  );

  always_comb begin
    st_nxt     = st_r;
    active_nxt = active_r;
    loaded_nxt = loaded_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    bidx_nxt   = bidx_r;
    bs_nxt     = bs_r;
    bd_nxt     = bd_r;
    q_ready    = 1'b0;
    we         = 1'b0;
    iss_go     = 1'b0;
    iss_use    = active_r[cnt_r];
    iss_last   = (cnt_r == LAST_IDX);
    load_out   = 1'b0;

    // strict compare keeps the lower index on ties
    if (res_go && res_use && (!found_r || (res_dsq < bd_r))) begin
      found_nxt = 1'b1;
      bidx_nxt  = res_idx;
      bs_nxt    = res_s;
      bd_nxt    = res_dsq;
    end

    case (st_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          case (q_cmd.kind)
            ACT_LOAD: begin
              we               = 1'b1;
              loaded_nxt[widx] = 1'b1;
              active_nxt[widx] = 1'b1;
            end
            ACT_SET: begin
              if (loaded_r[widx]) begin
                active_nxt[widx] = q_cmd.act;
              end
            end
            ACT_QUERY: begin
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              bidx_nxt  = '0;
              bs_nxt    = '0;
              bd_nxt    = '0;
              st_nxt    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        iss_go  = 1'b1;
        cnt_nxt = cnt_r + IW'(1);
        if (iss_last) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res_go && res_last) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    ov_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      active_r <= '0;
      loaded_r <= '0;
      ov_r     <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      active_r <= active_nxt;
      loaded_r <= loaded_nxt;
      ov_r     <= ov_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    bidx_r <= bidx_nxt;
    bs_r   <= bs_nxt;
    bd_r   <= bd_nxt;
    if ((st_r == ST_IDLE) && q_valid && (q_cmd.kind == ACT_QUERY)) begin
      px_r <= q_cmd.px;
      py_r <= q_cmd.py;
      pz_r <= q_cmd.pz;
    end
    if (load_out) begin
      of_r <= found_r;
      oi_r <= 6'(bidx_r);
      os_r <= bs_r;
      od_r <= bd_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_found          = of_r;
  assign out_lane_index     = oi_r;
  assign out_along_distance = os_r;
  assign out_dist_sq        = od_r;
endmodule

// ===== hdl/nearest_segment_query.sv =====
// Nearest line segment search over a table of SEGMENT_COUNT 3D segments.
// Input channel (in_valid/in_ready) carries one transaction per item:
//   load writes an entry and marks it loaded and active, set-active changes
//   the mark of a loaded entry, query scans the whole table. Unknown actions
//   and writes beyond the table are dropped without a result.
// Output channel (out_valid/out_ready) returns one transaction per query:
//   found, lane_index, along_distance (Q16.8) and dist_sq (Q36.16, saturated).
// A two-entry command queue sits between the input and the executing back end,
// so the input keeps accepting while a query runs, until the queue fills.
// Load and set-active are handled in the back end's idle state. A query issues one
// table read per cycle into an 8-stage distance pipeline, waits for the last
// result to drain, then loads the output register. The back end takes no new
// command until then; the single table read port sets the scan length.
// A result sits in an output register; if the receiver stalls, the next
// query scans anyway and waits only at hand-off. Loads go on while the back end is idle.
// Reset clears the loaded and active marks, the queue and the output valid;
// table contents are not cleared and no startup sweep is needed.
module nearest_segment_query #(
  parameter int SEGMENT_COUNT = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_action,
  input  logic [5:0]     in_seg_index,
  input  nsq_pkg::pos_t  in_point_x,
  input  nsq_pkg::pos_t  in_point_y,
  input  nsq_pkg::pos_t  in_point_z,
  input  nsq_pkg::dir_t  in_dir_x,
  input  nsq_pkg::dir_t  in_dir_y,
  input  nsq_pkg::dir_t  in_dir_z,
  input  nsq_pkg::len_t  in_seg_length,
  input  logic           in_active_flag,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_found,
  output logic [5:0]     out_lane_index,
  output nsq_pkg::len_t  out_along_distance,
  output nsq_pkg::dsq_t  out_dist_sq
);
  import nsq_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;

  nsq_front #(.SEGMENT_COUNT(SEGMENT_COUNT)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_seg_index   (in_seg_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .in_seg_length  (in_seg_length),
    .in_active_flag (in_active_flag),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd)
  );

  nsq_back #(.SEGMENT_COUNT(SEGMENT_COUNT)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_cmd              (q_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_lane_index     (out_lane_index),
    .out_along_distance (out_along_distance),
    .out_dist_sq        (out_dist_sq)
  );
endmodule
